// ===== rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types, codes and helpers of the i2c eeprom transaction sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

    // eeprom page size, a power of two
    localparam int PAGE_BYTES = 64;
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);
    localparam int PAGE_CW    = PAGE_AW + 1;

    localparam logic [7:0] RETRY_RESET = 8'd50;
    localparam logic [7:0] CTRL_BASE   = 8'hA0;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_DATA  = 2'd2,
        REQ_DONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_SEND  = 3'd2,
        OP_RECV  = 3'd3,
        OP_ACK   = 3'd4,
        OP_NACK  = 3'd5,
        OP_STOP  = 3'd6,
        OP_WAIT  = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_P_START,
        PH_P_CTRL,
        PH_P_WAIT,
        PH_A_HI,
        PH_A_LO,
        PH_W_NEED,
        PH_W_SEND,
        PH_W_STOP,
        PH_R_START,
        PH_R_CTRL,
        PH_R_RECV,
        PH_R_ACK,
        PH_R_NACK,
        PH_F_STOP
    } phase_t;

    typedef struct packed {
        req_t        req_type;
        logic [2:0]  device_number;
        logic [15:0] mem_address;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
        logic        bus_acked;
        logic [7:0]  read_byte;
    } item_t;

    typedef struct packed {
        op_t        bus_op;
        logic [7:0] bus_byte;
        logic       need_data;
        logic       data_valid;
        logic [7:0] data_out;
        logic       done_res;
        logic       success;
    } result_t;

    // bytes to send before the next page boundary, capped by the remaining count
    function automatic logic [PAGE_CW-1:0] load_page(input logic [15:0] addr,
                                                      input logic [15:0] bytes);
        logic [PAGE_CW-1:0] space;
        space = PAGE_CW'(PAGE_BYTES) - {1'b0, addr[PAGE_AW-1:0]};
        if (bytes < 16'(space))
            return bytes[PAGE_CW-1:0];
        else
            return space;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cee_core.sv =====
// ----------------------------------------------------------------------------
// i2cee_core
// transaction state and combinational decision of the next bus primitive
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire i2cee_pkg::item_t   item,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data,
    output i2cee_pkg::result_t      res
);

    i2cee_pkg::phase_t              phase_reg, phase_next;
    logic                           is_write_reg, is_write_next;
    logic [7:0]                     ctrl_reg, ctrl_next;
    logic [15:0]                    addr_reg, addr_next;
    logic [15:0]                    bytes_reg, bytes_next;
    logic [i2cee_pkg::PAGE_CW-1:0]  page_reg, page_next;
    logic [7:0]                     retries_reg, retries_next;
    logic [7:0]                     retry_limit_reg;
    logic [7:0]                     retries_dec;
    logic [15:0]                    bytes_dec;

    assign retries_dec = retries_reg - 8'd1;
    assign bytes_dec   = bytes_reg - 16'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        ctrl_next     = ctrl_reg;
        addr_next     = addr_reg;
        bytes_next    = bytes_reg;
        page_next     = page_reg;
        retries_next  = retries_reg;
        res           = '0;

        case (item.req_type) inside
            i2cee_pkg::REQ_READ, i2cee_pkg::REQ_WRITE:
            begin
                if (phase_reg == i2cee_pkg::PH_IDLE)
                begin
                    is_write_next = (item.req_type == i2cee_pkg::REQ_WRITE);
                    ctrl_next     = i2cee_pkg::CTRL_BASE | {4'b0000, item.device_number, 1'b0};
                    addr_next     = item.mem_address;
                    bytes_next    = item.byte_count;
                    page_next     = i2cee_pkg::load_page(item.mem_address, item.byte_count);
                    retries_next  = retry_limit_reg;
                    res.bus_op    = i2cee_pkg::OP_START;
                    phase_next    = i2cee_pkg::PH_P_START;
                end
            end
            i2cee_pkg::REQ_DATA:
            begin
                if (phase_reg == i2cee_pkg::PH_W_NEED)
                begin
                    res.bus_op   = i2cee_pkg::OP_SEND;
                    res.bus_byte = item.write_byte;
                    page_next    = page_reg - i2cee_pkg::PAGE_CW'(1);
                    bytes_next   = bytes_dec;
                    addr_next    = addr_reg + 16'd1;
                    phase_next   = i2cee_pkg::PH_W_SEND;
                end
            end
            default:
            begin
                unique case (phase_reg) inside
                    i2cee_pkg::PH_P_START:
                    begin
                        res.bus_op   = i2cee_pkg::OP_SEND;
                        res.bus_byte = ctrl_reg;
                        phase_next   = i2cee_pkg::PH_P_CTRL;
                    end
                    i2cee_pkg::PH_P_CTRL:
                    begin
                        if (item.bus_acked)
                        begin
                            res.bus_op   = i2cee_pkg::OP_SEND;
                            res.bus_byte = addr_reg[15:8];
                            phase_next   = i2cee_pkg::PH_A_HI;
                        end
                        else
                        begin
                            retries_next = retries_dec;
                            if (retries_dec == 8'd0)
                            begin
                                // polling gave up, no stop
                                res.done_res = 1'b1;
                                phase_next   = i2cee_pkg::PH_IDLE;
                            end
                            else
                            begin
                                res.bus_op = i2cee_pkg::OP_WAIT;
                                phase_next = i2cee_pkg::PH_P_WAIT;
                            end
                        end
                    end
                    i2cee_pkg::PH_P_WAIT:
                    begin
                        res.bus_op = i2cee_pkg::OP_START;
                        phase_next = i2cee_pkg::PH_P_START;
                    end
                    i2cee_pkg::PH_A_HI:
                    begin
                        res.bus_op   = i2cee_pkg::OP_SEND;
                        res.bus_byte = addr_reg[7:0];
                        phase_next   = i2cee_pkg::PH_A_LO;
                    end
                    i2cee_pkg::PH_A_LO, i2cee_pkg::PH_W_SEND:
                    begin
                        if (is_write_reg)
                        begin
                            if (page_reg != '0)
                            begin
                                res.need_data = 1'b1;
                                phase_next    = i2cee_pkg::PH_W_NEED;
                            end
                            else
                            begin
                                res.bus_op = i2cee_pkg::OP_STOP;
                                phase_next = (bytes_reg == 16'd0) ? i2cee_pkg::PH_F_STOP
                                                                  : i2cee_pkg::PH_W_STOP;
                            end
                        end
                        else if (bytes_reg == 16'd0)
                        begin
                            res.bus_op = i2cee_pkg::OP_STOP;
                            phase_next = i2cee_pkg::PH_F_STOP;
                        end
                        else
                        begin
                            res.bus_op = i2cee_pkg::OP_START;
                            phase_next = i2cee_pkg::PH_R_START;
                        end
                    end
                    i2cee_pkg::PH_W_STOP:
                    begin
                        // next page: poll and address again
                        page_next    = i2cee_pkg::load_page(addr_reg, bytes_reg);
                        retries_next = retry_limit_reg;
                        res.bus_op   = i2cee_pkg::OP_START;
                        phase_next   = i2cee_pkg::PH_P_START;
                    end
                    i2cee_pkg::PH_R_START:
                    begin
                        res.bus_op   = i2cee_pkg::OP_SEND;
                        res.bus_byte = ctrl_reg | 8'h01;
                        phase_next   = i2cee_pkg::PH_R_CTRL;
                    end
                    i2cee_pkg::PH_R_CTRL, i2cee_pkg::PH_R_ACK:
                    begin
                        res.bus_op = i2cee_pkg::OP_RECV;
                        phase_next = i2cee_pkg::PH_R_RECV;
                    end
                    i2cee_pkg::PH_R_RECV:
                    begin
                        res.data_valid = 1'b1;
                        res.data_out   = item.read_byte;
                        bytes_next     = bytes_dec;
                        addr_next      = addr_reg + 16'd1;
                        if (bytes_dec != 16'd0)
                        begin
                            res.bus_op = i2cee_pkg::OP_ACK;
                            phase_next = i2cee_pkg::PH_R_ACK;
                        end
                        else
                        begin
                            res.bus_op = i2cee_pkg::OP_NACK;
                            phase_next = i2cee_pkg::PH_R_NACK;
                        end
                    end
                    i2cee_pkg::PH_R_NACK:
                    begin
                        res.bus_op = i2cee_pkg::OP_STOP;
                        phase_next = i2cee_pkg::PH_F_STOP;
                    end
                    i2cee_pkg::PH_F_STOP:
                    begin
                        res.done_res = 1'b1;
                        res.success  = 1'b1;
                        phase_next   = i2cee_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        // completion while idle or waiting for data: ignored
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cee_pkg::PH_IDLE;
            is_write_reg    <= 1'b0;
            ctrl_reg        <= '0;
            addr_reg        <= '0;
            bytes_reg       <= '0;
            page_reg        <= '0;
            retries_reg     <= '0;
            retry_limit_reg <= i2cee_pkg::RETRY_RESET;
        end
        else
        begin
            if (cfg_we)
                retry_limit_reg <= cfg_data;
            if (step_en)
            begin
                phase_reg    <= phase_next;
                is_write_reg <= is_write_next;
                ctrl_reg     <= ctrl_next;
                addr_reg     <= addr_next;
                bytes_reg    <= bytes_next;
                page_reg     <= page_next;
                retries_reg  <= retries_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2cee_outq.sv =====
// ----------------------------------------------------------------------------
// i2cee_outq
// two-entry result queue, keeps the input side moving while the output stalls, until the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire i2cee_pkg::result_t  push_data,
    input  wire logic                pop_ready,
    output logic                     out_valid,
    output i2cee_pkg::result_t       out_data,
    output logic                     full
);

    i2cee_pkg::result_t  mem [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && pop_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_eeprom_transaction_sequencer_unit.sv =====
// a request is held in the input register, then decided and written into the result queue
// once the queue has a free slot; its result is then on m_axis and can be taken from there
// throughput: one request per cycle while the result queue is not full, one result per request
// the pace is set by the combinational decision in i2cee_core between input and result registers
// reset (rst_n low, asynchronous): sequencer idle, retry limit 50, input register and
// result queue empty
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer_unit
// top level: input register, sequencer core and result queue on stream ports
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_transaction_sequencer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: retry limit
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // device_number[2:0], mem_address[18:3], byte_count[34:19], write_byte[42:35],
    // bus_acked[43], read_byte[51:44], zero fill [55:52]
    input  wire logic [55:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // bus_byte[7:0], need_data[8], data_valid[9], data_out[17:10], done_res[18],
    // success[19], zero fill [23:20]
    output logic [23:0]      m_axis_tdata,
    // bus_op[2:0]
    output logic [2:0]       m_axis_tuser
);

    i2cee_pkg::item_t    in_item;
    i2cee_pkg::item_t    item_reg;
    logic                in_valid_reg;
    logic                step;
    logic                q_full;
    i2cee_pkg::result_t  step_res;
    i2cee_pkg::result_t  q_data;

    // unpack the request fields
    always_comb
    begin
        in_item.req_type      = i2cee_pkg::req_t'(s_axis_tuser);
        in_item.device_number = s_axis_tdata[2:0];
        in_item.mem_address   = s_axis_tdata[18:3];
        in_item.byte_count    = s_axis_tdata[34:19];
        in_item.write_byte    = s_axis_tdata[42:35];
        in_item.bus_acked     = s_axis_tdata[43];
        in_item.read_byte     = s_axis_tdata[51:44];
    end

    // the held request is decided as soon as the queue has a free slot
    assign step          = in_valid_reg && !q_full;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= in_item;
    end

    i2cee_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step),
        .item     (item_reg),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .res      (step_res)
    );

    i2cee_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_res),
        .pop_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (q_data),
        .full      (q_full)
    );

    // pack the result fields
    assign m_axis_tuser = q_data.bus_op;
    assign m_axis_tdata = {4'b0000, q_data.success, q_data.done_res, q_data.data_out,
                           q_data.data_valid, q_data.need_data, q_data.bus_byte};

endmodule

`default_nettype wire

// ===== rtl/i2cee_checker.sv =====
// ----------------------------------------------------------------------------
// i2cee_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // success only with done
    a_success: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[18])
        else $error("success without done");

    // bus byte only carried with a send
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != i2cee_pkg::OP_SEND) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("bus byte without send");

    // a read byte comes with its ack or nack
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |->
            (m_axis_tuser == i2cee_pkg::OP_ACK) || (m_axis_tuser == i2cee_pkg::OP_NACK))
        else $error("read byte without ack or nack");

    // a data request drives no primitive and ends nothing
    a_need: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] |->
            (m_axis_tuser == i2cee_pkg::OP_NONE) && !m_axis_tdata[18])
        else $error("data request with primitive or done");

endmodule

bind i2c_eeprom_transaction_sequencer_unit i2cee_checker u_i2cee_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
